[hw/rtl/tqce_pkg.sv]
package tqce_pkg;

  localparam int NUM_CITIES    = 3;
  localparam int DISTANCE_BITS = 16;

  localparam int CELLS        = NUM_CITIES * NUM_CITIES;
  localparam int CELL_W       = $clog2(CELLS);
  localparam int CITY_W       = 2;
  localparam int DIST_IN_W    = 16;
  localparam int ASSIGN_W     = 9;
  localparam int ASSIGN_IDX_W = $clog2(ASSIGN_W);
  localparam int PW_W         = 16;

  localparam int CNT_W    = $clog2(NUM_CITIES + 1);
  localparam int PROD_W   = DISTANCE_BITS + CNT_W;
  localparam int ROW_W    = PROD_W + $clog2(NUM_CITIES);
  localparam int TOUR_W   = ROW_W + $clog2(NUM_CITIES);
  localparam int PEN_MAX  = 2 * NUM_CITIES * (NUM_CITIES - 1) * (NUM_CITIES - 1);
  localparam int PEN_W    = $clog2(PEN_MAX + 1);
  localparam int PWPEN_W  = PW_W + PEN_W;
  localparam int TOTAL_W  = ((TOUR_W > PWPEN_W) ? TOUR_W : PWPEN_W) + 1;

  localparam int TOUR_OUT_W = 21;
  localparam int COST_OUT_W = 24;
  localparam int TOUR_CMP_W = (TOUR_W > TOUR_OUT_W) ? TOUR_W : TOUR_OUT_W;
  localparam int COST_CMP_W = (TOTAL_W > COST_OUT_W) ? TOTAL_W : COST_OUT_W;
  localparam logic [TOUR_OUT_W-1:0] TOUR_MAX = '1;
  localparam logic [COST_OUT_W-1:0] COST_MAX = '1;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USED_W  = 2 * CITY_W + DIST_IN_W + ASSIGN_W;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USED_W = COST_OUT_W + TOUR_OUT_W + 1;

  localparam logic [PW_W-1:0] PENALTY_RESET = 16'd500;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  typedef logic [CELLS-1:0][DISTANCE_BITS-1:0] dist_table_t;

  typedef struct packed {
    logic [CELLS-1:0][PROD_W-1:0] prod;
    logic [PEN_W-1:0]             pen;
    logic                         one_hot;
  } term_t;

  function automatic logic asg_bit(input logic [ASSIGN_W-1:0] a, input int step,
                                   input int city);
    int pos;
    pos = step * NUM_CITIES + city;
    return (pos < ASSIGN_W) ? a[pos[ASSIGN_IDX_W-1:0]] : 1'b0;
  endfunction

  function automatic logic [PEN_W-1:0] penalty_of(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] dev;
    dev = c - CNT_W'(1);
    return (c == '0) ? PEN_W'(1) : PEN_W'(PEN_W'(dev) * PEN_W'(dev));
  endfunction

endpackage

[hw/rtl/tqce_dist_table.sv]
module tqce_dist_table import tqce_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [CITY_W-1:0]    from_city,
  input  logic [CITY_W-1:0]    to_city,
  input  logic [DIST_IN_W-1:0] distance_value,
  output dist_table_t          dist_tbl
);

  dist_table_t      dist_r;
  logic [CELL_W-1:0] cell_idx;
  logic              in_range;

  assign in_range = (int'(from_city) < NUM_CITIES) && (int'(to_city) < NUM_CITIES);
  assign cell_idx = CELL_W'(int'(from_city) * NUM_CITIES + int'(to_city));

  always_ff @(posedge clk) begin
    if (we && in_range) begin
      dist_r[cell_idx] <= DISTANCE_BITS'(distance_value);
    end
  end

  assign dist_tbl = dist_r;

endmodule

[hw/rtl/tqce_term_stage.sv]
module tqce_term_stage import tqce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ASSIGN_W-1:0] assignment,
  input  dist_table_t         dist_tbl,
  output logic                out_valid,
  input  logic                out_ready,
  output term_t               term
);

  logic  v_r;
  term_t term_r;
  term_t term_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [PEN_W-1:0] pen;
    logic             oh;
    term_nxt = '0;
    pen      = '0;
    oh       = 1'b1;
    // visits of each ordered city pair on consecutive steps
    for (int i = 0; i < NUM_CITIES; i++) begin
      for (int j = 0; j < NUM_CITIES; j++) begin
        cnt = '0;
        for (int t = 0; t < NUM_CITIES; t++) begin
          cnt = cnt + CNT_W'(asg_bit(assignment, t, i) &
                             asg_bit(assignment, (t + 1) % NUM_CITIES, j));
        end
        // unused pairs contribute nothing, whatever the entry holds
        term_nxt.prod[i*NUM_CITIES+j] = (cnt == '0) ? '0 :
            PROD_W'(PROD_W'(cnt) * PROD_W'(dist_tbl[i*NUM_CITIES+j]));
      end
    end
    // city columns
    for (int i = 0; i < NUM_CITIES; i++) begin
      cnt = '0;
      for (int t = 0; t < NUM_CITIES; t++) begin
        cnt = cnt + CNT_W'(asg_bit(assignment, t, i));
      end
      pen = pen + penalty_of(cnt);
    end
    // time rows
    for (int t = 0; t < NUM_CITIES; t++) begin
      cnt = '0;
      for (int i = 0; i < NUM_CITIES; i++) begin
        cnt = cnt + CNT_W'(asg_bit(assignment, t, i));
      end
      pen = pen + penalty_of(cnt);
      if (cnt != CNT_W'(1)) begin
        oh = 1'b0;
      end
    end
    term_nxt.pen     = pen;
    term_nxt.one_hot = oh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      term_r <= term_nxt;
    end
  end

  assign out_valid = v_r;
  assign term      = term_r;

endmodule

[hw/rtl/tqce_sum_stage.sv]
module tqce_sum_stage import tqce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  term_t                 term,
  input  logic [PW_W-1:0]       penalty_weight,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COST_OUT_W-1:0] total_cost,
  output logic [TOUR_OUT_W-1:0] tour_length,
  output logic                  rows_one_hot
);

  logic                              v2_r;
  logic [NUM_CITIES-1:0][ROW_W-1:0]  row_r;
  logic [NUM_CITIES-1:0][ROW_W-1:0]  row_nxt;
  logic [PWPEN_W-1:0]                pwpen_r;
  logic                              oh2_r;

  logic                              v3_r;
  logic [COST_OUT_W-1:0]             total_r;
  logic [COST_OUT_W-1:0]             total_nxt;
  logic [TOUR_OUT_W-1:0]             tour_r;
  logic [TOUR_OUT_W-1:0]             tour_nxt;
  logic                              oh3_r;

  logic                              rdy2;
  logic                              rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = rdy2;

  always_comb begin
    for (int i = 0; i < NUM_CITIES; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NUM_CITIES; j++) begin
        row_nxt[i] = row_nxt[i] + ROW_W'(term.prod[i*NUM_CITIES+j]);
      end
    end
  end

  always_comb begin
    logic [TOUR_W-1:0]  tour;
    logic [TOTAL_W-1:0] total;
    tour = '0;
    for (int i = 0; i < NUM_CITIES; i++) begin
      tour = tour + TOUR_W'(row_r[i]);
    end
    total     = TOTAL_W'(tour) + TOTAL_W'(pwpen_r);
    tour_nxt  = (TOUR_CMP_W'(tour) > TOUR_CMP_W'(TOUR_MAX)) ? TOUR_MAX
                                                           : TOUR_OUT_W'(tour);
    total_nxt = (COST_CMP_W'(total) > COST_CMP_W'(COST_MAX)) ? COST_MAX
                                                            : COST_OUT_W'(total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= in_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
    if (rdy2 && in_valid) begin
      row_r   <= row_nxt;
      pwpen_r <= PWPEN_W'(PWPEN_W'(penalty_weight) * PWPEN_W'(term.pen));
      oh2_r   <= term.one_hot;
    end
    if (rdy3 && v2_r) begin
      total_r <= total_nxt;
      tour_r  <= tour_nxt;
      oh3_r   <= oh2_r;
    end
  end

  assign out_valid    = v3_r;
  assign total_cost   = total_r;
  assign tour_length  = tour_r;
  assign rows_one_hot = oh3_r;

endmodule

[hw/rtl/tsp_qubo_cost_evaluator.sv]
// Travelling-salesman QUBO cost evaluator. A transaction with in_tuser = 1 evaluates the
// assignment bitstring (bit step*N+city set means the city is visited at that step) and
// returns one result: tour length, tour length plus penalty_weight*(count-1)^2 summed over
// every city column and time row (saturating), and a flag that every time row is one-hot.
// A transaction with in_tuser = 0 writes one entry of the distance table (no result);
// writes take effect in order with the evaluations around them, and entries with a city
// index out of range are ignored. Every table entry must be written before it is read.
// One transaction is taken every cycle while no back-pressure holds the pipeline; a result
// passes the input register and the three pipeline registers (pair terms, row sums and
// penalty product, final sum and saturation) in that order. Back-pressure on out_tready
// stalls only the stages that are full. penalty_weight is written on the cfg channel,
// which is always ready.
module tsp_qubo_cost_evaluator import tqce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // from_city, to_city, distance_value, assignment, zero padding
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // total_cost, tour_length, rows_one_hot, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PW_W-1:0]       cfg_data
);

  logic                 pw_valid_unused;
  logic [PW_W-1:0]      pw_r;

  logic                 s0_v_r;
  logic                 s0_act_r;
  logic [CITY_W-1:0]    s0_from_r;
  logic [CITY_W-1:0]    s0_to_r;
  logic [DIST_IN_W-1:0] s0_dist_r;
  logic [ASSIGN_W-1:0]  s0_asg_r;
  logic                 s0_go;
  logic                 s0_eval;
  logic                 s0_write;

  dist_table_t          dist_tbl;
  logic                 term_ready;
  logic                 term_valid;
  term_t                term;
  logic                 sum_ready;

  logic [COST_OUT_W-1:0] total_cost;
  logic [TOUR_OUT_W-1:0] tour_length;
  logic                  rows_one_hot;

  assign cfg_ready       = 1'b1;
  assign pw_valid_unused = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r <= PENALTY_RESET;
    end else if (pw_valid_unused) begin
      pw_r <= cfg_data;
    end
  end

  assign s0_eval   = s0_v_r && (s0_act_r == ACT_EVAL);
  assign s0_write  = s0_v_r && (s0_act_r == ACT_WRITE);
  assign s0_go     = s0_write || (s0_eval && term_ready);
  assign in_tready = !s0_v_r || s0_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_tready) begin
      s0_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s0_act_r  <= in_tuser;
      s0_from_r <= in_tdata[CITY_W-1:0];
      s0_to_r   <= in_tdata[2*CITY_W-1:CITY_W];
      s0_dist_r <= in_tdata[2*CITY_W+DIST_IN_W-1:2*CITY_W];
      s0_asg_r  <= in_tdata[IN_USED_W-1:2*CITY_W+DIST_IN_W];
    end
  end

  tqce_dist_table u_table (
    .clk            (clk),
    .we             (s0_write),
    .from_city      (s0_from_r),
    .to_city        (s0_to_r),
    .distance_value (s0_dist_r),
    .dist_tbl       (dist_tbl)
  );

  tqce_term_stage u_term (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s0_eval),
    .in_ready   (term_ready),
    .assignment (s0_asg_r),
    .dist_tbl   (dist_tbl),
    .out_valid  (term_valid),
    .out_ready  (sum_ready),
    .term       (term)
  );

  tqce_sum_stage u_sum (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (term_valid),
    .in_ready       (sum_ready),
    .term           (term),
    .penalty_weight (pw_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .total_cost     (total_cost),
    .tour_length    (tour_length),
    .rows_one_hot   (rows_one_hot)
  );

  assign out_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, rows_one_hot, tour_length,
                      total_cost};

endmodule

[hw/rtl/tqce_checker.sv]
module tqce_checker import tqce_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [PW_W-1:0]       cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // cost never below the tour length it contains
  a_cost_ge_tour: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[COST_OUT_W-1:0] >=
                    COST_OUT_W'(out_tdata[COST_OUT_W+TOUR_OUT_W-1:COST_OUT_W])))
    else $error("total cost below tour length");

  // result padding stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
    else $error("result padding not zero");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind tsp_qubo_cost_evaluator tqce_checker u_tqce_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tqce_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int SETTLE = 8;
  localparam int N_PLAN = 24;
  localparam int N_RAND = 175;

  typedef struct packed {
    logic [COST_OUT_W-1:0] cost;
    logic [TOUR_OUT_W-1:0] tour;
    logic                  one_hot;
  } energy_t;

  typedef struct packed {
    logic                  act;
    logic [CITY_W-1:0]     fc;
    logic [CITY_W-1:0]     tc;
    logic [DIST_IN_W-1:0]  dval;
    logic [ASSIGN_W-1:0]   asg;
    logic                  fixed;
    logic [COST_OUT_W-1:0] cost;
    logic [TOUR_OUT_W-1:0] tour;
    logic                  one_hot;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PW_W-1:0]       cfg_data;

  logic [DISTANCE_BITS-1:0] dist_mem [CELLS];
  logic [PW_W-1:0]          pen_weight;
  energy_t                  energy_q [$];
  plan_row_t                plan [N_PLAN];
  int                       n_fail = 0;
  int                       cyc = 0;
  int                       choke_left = 0;
  int                       rx_hold = 0;
  bit                       tx_fast = 1'b0;
  bit                       rx_fast = 1'b0;

  always #4 clk = ~clk;

  tsp_qubo_cost_evaluator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tour length plus weighted one-hot penalties
  function automatic energy_t qubo_energy(input logic [ASSIGN_W-1:0] a);
    energy_t     r;
    logic [47:0] tour;
    logic [47:0] total;
    int          pen, cnt, nt, t, i, j;
    tour = '0;
    pen = 0;
    r.one_hot = 1'b1;
    for (t = 0; t < NUM_CITIES; t++) begin
      nt = (t + 1) % NUM_CITIES;
      for (i = 0; i < NUM_CITIES; i++) begin
        if (a[t*NUM_CITIES+i]) begin
          for (j = 0; j < NUM_CITIES; j++) begin
            if (a[nt*NUM_CITIES+j]) tour += 48'(dist_mem[i*NUM_CITIES+j]);
          end
        end
      end
    end
    for (i = 0; i < NUM_CITIES; i++) begin
      cnt = 0;
      for (t = 0; t < NUM_CITIES; t++) cnt += int'(a[t*NUM_CITIES+i]);
      pen += (cnt == 0) ? 1 : (cnt - 1) * (cnt - 1);
    end
    for (t = 0; t < NUM_CITIES; t++) begin
      cnt = 0;
      for (i = 0; i < NUM_CITIES; i++) cnt += int'(a[t*NUM_CITIES+i]);
      if (cnt != 1) r.one_hot = 1'b0;
      pen += (cnt == 0) ? 1 : (cnt - 1) * (cnt - 1);
    end
    total = tour + 48'(pen_weight) * 48'(pen);
    r.cost = (total > 48'(COST_MAX)) ? COST_MAX : total[COST_OUT_W-1:0];
    r.tour = (tour > 48'(TOUR_MAX)) ? TOUR_MAX : tour[TOUR_OUT_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic act, input logic [CITY_W-1:0] fc,
                           input logic [CITY_W-1:0] tc, input logic [DIST_IN_W-1:0] dval,
                           input logic [ASSIGN_W-1:0] asg, input logic fixed,
                           input energy_t want);
    int      gap;
    energy_t e;
    gap = tx_fast ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_DATA_W'({asg, dval, tc, fc});
    do @(posedge clk); while (!in_tready);
    if (act == ACT_EVAL) begin
      e = fixed ? want : qubo_energy(asg);
      energy_q.push_back(e);
    end else if (fc < NUM_CITIES && tc < NUM_CITIES) begin
      dist_mem[fc*NUM_CITIES+tc] = dval;
    end
  endtask

  task automatic rand_item();
    int                    r, p0, p1;
    logic [CITY_W-1:0]     fc, tc;
    logic [DIST_IN_W-1:0]  dval;
    logic [ASSIGN_W-1:0]   asg;
    energy_t               none;
    r = $urandom_range(99);
    fc = CITY_W'($urandom_range(3));
    tc = CITY_W'($urandom_range(3));
    dval = DIST_IN_W'($urandom);
    asg = ASSIGN_W'($urandom);
    none = '0;
    if (r < 25) begin
      if ($urandom_range(9) != 0) begin
        fc = CITY_W'($urandom_range(NUM_CITIES - 1));
        tc = CITY_W'($urandom_range(NUM_CITIES - 1));
      end
      case ($urandom_range(9))
        0: dval = '0;
        1: dval = '1;
        default: ;
      endcase
      send_item(ACT_WRITE, fc, tc, dval, asg, 1'b0, none);
    end else begin
      // mostly valid tours, some with one bit flipped
      if (r < 80) begin
        p0 = $urandom_range(2);
        p1 = (p0 + 1 + $urandom_range(1)) % 3;
        asg = '0;
        asg[p0] = 1'b1;
        asg[NUM_CITIES+p1] = 1'b1;
        asg[2*NUM_CITIES+3-p0-p1] = 1'b1;
        if ($urandom_range(4) == 0) asg[$urandom_range(ASSIGN_W - 1)] ^= 1'b1;
      end
      send_item(ACT_EVAL, fc, tc, dval, asg, 1'b0, none);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_weight(input logic [PW_W-1:0] w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    pen_weight = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (choke_left > 0) begin
      out_tready <= 1'b0;
      choke_left--;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else if (rx_fast) begin
      out_tready <= 1'b1;
    end else begin
      rx_hold = gap_len();
      out_tready <= (rx_hold == 0);
      if (rx_hold > 0) rx_hold--;
    end
  end

  always @(posedge clk) begin
    energy_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.cost    = out_tdata[COST_OUT_W-1:0];
      got.tour    = out_tdata[COST_OUT_W +: TOUR_OUT_W];
      got.one_hot = out_tdata[COST_OUT_W+TOUR_OUT_W];
      if (energy_q.size() == 0) begin
        $display("%0t: unexpected result transaction, data %h", $time, out_tdata);
        n_fail++;
      end else begin
        want = energy_q.pop_front();
        if (got.cost !== want.cost) begin
          $display("%0t: total_cost expected %0d actual %0d", $time, want.cost, got.cost);
          n_fail++;
        end
        if (got.tour !== want.tour) begin
          $display("%0t: tour_length expected %0d actual %0d", $time, want.tour, got.tour);
          n_fail++;
        end
        if (got.one_hot !== want.one_hot) begin
          $display("%0t: rows_one_hot expected %0d actual %0d", $time, want.one_hot,
                   got.one_hot);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int              k, p, n;
    logic [PW_W-1:0] weights [4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = ACT_WRITE;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    pen_weight = PENALTY_RESET;
    weights[0] = '1;
    weights[1] = '0;
    weights[2] = PW_W'($urandom_range(2, 65534));
    weights[3] = 16'd1;
    // act, from, to, distance, assignment, fixed, cost, tour, one-hot
    plan = '{
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h000, 1'b1, 3000, 0, 1'b0},
      '{ACT_WRITE, 2'd0, 2'd0, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd0, 2'd1, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd0, 2'd2, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd1, 2'd0, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd1, 2'd1, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd1, 2'd2, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd2, 2'd0, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd2, 2'd1, 16'hFFFF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd2, 2'd2, 16'hFFFF, 9'h1FF, 1'b0, 0, 0, 1'b0},
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h1FF, 1'b1, 1781445, 1769445, 1'b0},
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h111, 1'b1, 196605, 196605, 1'b1},
      '{ACT_WRITE, 2'd3, 2'd1, 16'h0000, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd1, 2'd3, 16'h0000, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd3, 2'd3, 16'h0000, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h1FF, 1'b1, 1781445, 1769445, 1'b0},
      '{ACT_WRITE, 2'd0, 2'd1, 16'h0000, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd2, 2'd0, 16'h1234, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_WRITE, 2'd1, 2'd1, 16'h00FF, 9'h000, 1'b0, 0, 0, 1'b0},
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h111, 1'b0, 0, 0, 1'b0},
      '{ACT_EVAL,  2'd3, 2'd3, 16'hFFFF, 9'h0A5, 1'b0, 0, 0, 1'b0},
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h1FF, 1'b0, 0, 0, 1'b0},
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h10A, 1'b0, 0, 0, 1'b0},
      '{ACT_EVAL,  2'd0, 2'd0, 16'h0000, 9'h000, 1'b1, 3000, 0, 1'b0}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_PLAN; k++) begin
      send_item(plan[k].act, plan[k].fc, plan[k].tc, plan[k].dval, plan[k].asg,
                plan[k].fixed, energy_t'({plan[k].cost, plan[k].tour, plan[k].one_hot}));
    end

    for (p = 0; p < 4; p++) begin
      drain();
      write_weight(weights[p]);
      @(posedge clk);
      tx_fast = (p == 1 || p == 2);
      rx_fast = (p == 2);
      // long output stall while input keeps streaming
      if (p == 1) choke_left = 150;
      for (n = 0; n < N_RAND; n++) begin
        if (p == 2 && n == N_RAND / 2) begin
          tx_fast = 1'b0;
          rx_fast = 1'b0;
        end
        rand_item();
      end
    end

    drain();
    if (n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
